// File: rtl/lru_page_buffer_pool_defines.svh
// Assertion macros for the buffer pool frame manager.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef LRU_PAGE_BUFFER_POOL_DEFINES_SVH
`define LRU_PAGE_BUFFER_POOL_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define LPBP_ASSERT_ALWAYS(label, cond, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define LPBP_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lpbp_pkg.sv
// Shared types and constants for the buffer pool frame manager.
// No dependencies.
package lpbp_pkg;

    localparam int FRAMES_DEF  = 16;
    localparam int FILE_W      = 10;
    localparam int PAGE_W      = 32;
    localparam int OP_W        = 3;
    localparam int OUT_FRAME_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_GET,
        OP_ALLOC,
        OP_DIRTY,
        OP_FPAGE,
        OP_FFILE,
        OP_FALL,
        OP_CLEAR
    } op_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_DISP,
        S_UPD,
        S_RANK,
        S_RNEXT,
        S_WB,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        U_HIT,
        U_ACQ,
        U_FLUSH,
        U_REL
    } upd_t;

    typedef struct packed {
        logic              en;
        logic [FILE_W-1:0] file;
        logic [PAGE_W-1:0] page;
    } tag_wr_t;

    typedef struct packed {
        logic                   vld;
        logic                   last;
        logic [OUT_FRAME_W-1:0] frame;
        logic                   hit;
        logic                   read_needed;
        logic                   error;
        logic [FILE_W-1:0]      file;
        logic [PAGE_W-1:0]      page;
    } emit_t;

endpackage

// File: rtl/lpbp_frame_store.sv
// Per-frame tag memory and list-position memory, one read a cycle, with separate tag and position writes.
// Depends on lpbp_pkg.
module lpbp_frame_store #(
    parameter int FRAMES = lpbp_pkg::FRAMES_DEF
) (
    input  logic                        clk,
    input  logic [$clog2(FRAMES)-1:0]   rd_addr,
    output logic [lpbp_pkg::FILE_W-1:0] rd_file,
    output logic [lpbp_pkg::PAGE_W-1:0] rd_page,
    output logic [$clog2(FRAMES)-1:0]   rd_pos,
    input  lpbp_pkg::tag_wr_t           tag_wr,
    input  logic [$clog2(FRAMES)-1:0]   tag_addr,
    input  logic                        pos_we,
    input  logic [$clog2(FRAMES)-1:0]   pos_addr,
    input  logic [$clog2(FRAMES)-1:0]   pos_wdata
);
    import lpbp_pkg::*;

    localparam int FW = $clog2(FRAMES);

    logic [FILE_W-1:0] file_mem [FRAMES];
    logic [PAGE_W-1:0] page_mem [FRAMES];
    logic [FW-1:0]     pos_mem  [FRAMES];

    logic [FILE_W-1:0] rd_file_reg;
    logic [PAGE_W-1:0] rd_page_reg;
    logic [FW-1:0]     rd_pos_reg;

    always_ff @(posedge clk)
    begin
        if (tag_wr.en)
        begin
            file_mem[tag_addr] <= tag_wr.file;
            page_mem[tag_addr] <= tag_wr.page;
        end
        if (pos_we)
        begin
            pos_mem[pos_addr] <= pos_wdata;
        end
        rd_file_reg <= file_mem[rd_addr];
        rd_page_reg <= page_mem[rd_addr];
        rd_pos_reg  <= pos_mem[rd_addr];
    end

    assign rd_file = rd_file_reg;
    assign rd_page = rd_page_reg;
    assign rd_pos  = rd_pos_reg;

endmodule

// File: rtl/lpbp_ctrl.sv
// Sequencer of the frame manager: frame scans, list-position updates, results.
// Depends on lpbp_pkg; drives lpbp_frame_store ports.
module lpbp_ctrl #(
    parameter int FRAMES = lpbp_pkg::FRAMES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_accept,
    input  logic [lpbp_pkg::OP_W-1:0]     opcode,
    input  logic [lpbp_pkg::FILE_W-1:0]   file_id,
    input  logic [lpbp_pkg::PAGE_W-1:0]   page_number,
    output logic                          in_ready,
    output lpbp_pkg::emit_t               emit,
    input  logic                          emit_take,
    output logic [$clog2(FRAMES)-1:0]     rd_addr,
    input  logic [lpbp_pkg::FILE_W-1:0]   rd_file,
    input  logic [lpbp_pkg::PAGE_W-1:0]   rd_page,
    input  logic [$clog2(FRAMES)-1:0]     rd_pos,
    output lpbp_pkg::tag_wr_t             tag_wr,
    output logic [$clog2(FRAMES)-1:0]     tag_addr,
    output logic                          pos_we,
    output logic [$clog2(FRAMES)-1:0]     pos_addr,
    output logic [$clog2(FRAMES)-1:0]     pos_wdata,
    output logic [$clog2(FRAMES+1)-1:0]   busy_cnt,
    output logic [$clog2(FRAMES+1)-1:0]   free_cnt
);
    import lpbp_pkg::*;

    localparam int FW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam logic [FW-1:0] LAST = FW'(FRAMES - 1);

    // control state
    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    upd_t              upd_reg, upd_next;
    logic [FW-1:0]     cnt_reg, cnt_next;
    logic              iss_reg, iss_next;
    logic              pv_reg, pv_next;
    logic              found_reg, found_next;
    logic              from_free_reg, from_free_next;
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [FRAMES-1:0] dirty_reg, dirty_next;
    logic [CW-1:0]     busy_reg, busy_next;
    logic [CW-1:0]     free_reg, free_next;
    logic [CW-1:0]     rk_cnt_reg, rk_cnt_next;

    // payload
    op_t               op_reg, op_next;
    logic [FILE_W-1:0] f_reg, f_next;
    logic [PAGE_W-1:0] p_reg, p_next;
    logic [FW-1:0]     pi_reg, pi_next;
    logic [FW-1:0]     idx_reg, idx_next;
    logic [FW-1:0]     rank_reg, rank_next;
    logic [FW-1:0]     head_reg, head_next;
    logic [FW-1:0]     tail_reg, tail_next;
    logic [FILE_W-1:0] tail_file_reg, tail_file_next;
    logic [PAGE_W-1:0] tail_page_reg, tail_page_next;
    logic [FILE_W-1:0] m_file_reg, m_file_next;
    logic [PAGE_W-1:0] m_page_reg, m_page_next;
    logic [FW-1:0]     fr_reg, fr_next;
    logic [FW-1:0]     wb_frame_reg, wb_frame_next;
    logic [FILE_W-1:0] wb_file_reg, wb_file_next;
    logic [PAGE_W-1:0] wb_page_reg, wb_page_next;
    logic [FW-1:0]     fin_frame_reg, fin_frame_next;
    logic              fin_hit_reg, fin_hit_next;
    logic              fin_rd_reg, fin_rd_next;
    logic              fin_err_reg, fin_err_next;

    logic scan_go;
    logic scan_done;

    assign scan_done = pv_reg && (pi_reg == LAST);
    assign busy_cnt  = busy_reg;
    assign free_cnt  = free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ret_reg       <= S_UPD;
            upd_reg       <= U_HIT;
            cnt_reg       <= '0;
            iss_reg       <= 1'b0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            from_free_reg <= 1'b0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            busy_reg      <= '0;
            free_reg      <= CW'(FRAMES);
            rk_cnt_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            upd_reg       <= upd_next;
            cnt_reg       <= cnt_next;
            iss_reg       <= iss_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            from_free_reg <= from_free_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            busy_reg      <= busy_next;
            free_reg      <= free_next;
            rk_cnt_reg    <= rk_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        f_reg         <= f_next;
        p_reg         <= p_next;
        pi_reg        <= pi_next;
        idx_reg       <= idx_next;
        rank_reg      <= rank_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        tail_file_reg <= tail_file_next;
        tail_page_reg <= tail_page_next;
        m_file_reg    <= m_file_next;
        m_page_reg    <= m_page_next;
        fr_reg        <= fr_next;
        wb_frame_reg  <= wb_frame_next;
        wb_file_reg   <= wb_file_next;
        wb_page_reg   <= wb_page_next;
        fin_frame_reg <= fin_frame_next;
        fin_hit_reg   <= fin_hit_next;
        fin_rd_reg    <= fin_rd_next;
        fin_err_reg   <= fin_err_next;
    end

    always_comb
    begin
        logic          v_i;
        logic [FW-1:0] fr_sel;
        logic [FW-1:0] pos_n;

        state_next     = state_reg;
        ret_next       = ret_reg;
        upd_next       = upd_reg;
        cnt_next       = cnt_reg;
        iss_next       = 1'b0;
        pv_next        = 1'b0;
        found_next     = found_reg;
        from_free_next = from_free_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        busy_next      = busy_reg;
        free_next      = free_reg;
        rk_cnt_next    = rk_cnt_reg;
        op_next        = op_reg;
        f_next         = f_reg;
        p_next         = p_reg;
        pi_next        = pi_reg;
        idx_next       = idx_reg;
        rank_next      = rank_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        tail_file_next = tail_file_reg;
        tail_page_next = tail_page_reg;
        m_file_next    = m_file_reg;
        m_page_next    = m_page_reg;
        fr_next        = fr_reg;
        wb_frame_next  = wb_frame_reg;
        wb_file_next   = wb_file_reg;
        wb_page_next   = wb_page_reg;
        fin_frame_next = fin_frame_reg;
        fin_hit_next   = fin_hit_reg;
        fin_rd_next    = fin_rd_reg;
        fin_err_next   = fin_err_reg;

        in_ready  = 1'b0;
        scan_go   = 1'b0;
        rd_addr   = cnt_reg;
        pos_we    = 1'b0;
        pos_addr  = pi_reg;
        pos_wdata = rd_pos;
        tag_wr    = '{en: 1'b0, file: f_reg, page: p_reg};
        tag_addr  = fr_reg;
        emit      = '0;
        v_i       = valid_reg[pi_reg];
        fr_sel    = '0;
        pos_n     = rd_pos;

        // one frame a cycle: issue a read, handle its data in the cycle after
        if (state_reg == S_LOOK || state_reg == S_UPD || state_reg == S_RANK)
        begin
            if (iss_reg)
            begin
                pv_next  = 1'b1;
                pi_next  = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                iss_next = (cnt_reg != LAST);
            end
        end

        case (state_reg)
            S_INIT:
            begin
                // free list starts as frames in ascending order
                pos_we    = 1'b1;
                pos_addr  = cnt_reg;
                pos_wdata = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_accept)
                begin
                    op_next    = op_t'(opcode);
                    f_next     = file_id;
                    p_next     = page_number;
                    found_next = 1'b0;
                    state_next = S_LOOK;
                    scan_go    = 1'b1;
                end
            end

            S_LOOK:
            begin
                if (pv_reg)
                begin
                    if (!found_reg && v_i && rd_file == f_reg
                        && (op_reg == OP_FFILE || rd_page == p_reg))
                    begin
                        found_next  = 1'b1;
                        idx_next    = pi_reg;
                        rank_next   = rd_pos;
                        m_file_next = rd_file;
                        m_page_next = rd_page;
                    end
                    if (v_i && rd_pos == FW'(busy_reg - CW'(1)))
                    begin
                        tail_next      = pi_reg;
                        tail_file_next = rd_file;
                        tail_page_next = rd_page;
                    end
                    if (!v_i && rd_pos == '0)
                    begin
                        head_next = pi_reg;
                    end
                end
                if (scan_done)
                begin
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                fin_frame_next = '0;
                fin_hit_next   = 1'b0;
                fin_rd_next    = 1'b0;
                fin_err_next   = 1'b0;
                state_next     = S_FIN;
                case (op_reg)
                    OP_GET, OP_ALLOC:
                    begin
                        if (found_reg)
                        begin
                            fin_frame_next = idx_reg;
                            fin_hit_next   = 1'b1;
                            if (op_reg == OP_GET)
                            begin
                                fr_next    = idx_reg;
                                upd_next   = U_HIT;
                                state_next = S_UPD;
                                scan_go    = 1'b1;
                            end
                            else
                            begin
                                fin_err_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (free_reg != '0)
                            begin
                                fr_sel         = head_reg;
                                from_free_next = 1'b1;
                                free_next      = free_reg - 1'b1;
                                busy_next      = busy_reg + 1'b1;
                                state_next     = S_UPD;
                                scan_go        = 1'b1;
                            end
                            else
                            begin
                                // evict the least recent frame
                                fr_sel         = tail_reg;
                                from_free_next = 1'b0;
                                if (dirty_reg[tail_reg])
                                begin
                                    wb_frame_next = tail_reg;
                                    wb_file_next  = tail_file_reg;
                                    wb_page_next  = tail_page_reg;
                                    ret_next      = S_UPD;
                                    state_next    = S_WB;
                                end
                                else
                                begin
                                    state_next = S_UPD;
                                    scan_go    = 1'b1;
                                end
                            end
                            valid_next[fr_sel] = 1'b1;
                            dirty_next[fr_sel] = 1'b0;
                            tag_wr.en          = 1'b1;
                            tag_addr           = fr_sel;
                            fr_next            = fr_sel;
                            upd_next           = U_ACQ;
                            fin_frame_next     = fr_sel;
                            fin_rd_next        = (op_reg == OP_GET);
                        end
                    end

                    OP_DIRTY:
                    begin
                        if (found_reg)
                        begin
                            dirty_next[idx_reg] = 1'b1;
                            fin_frame_next      = idx_reg;
                            fin_hit_next        = 1'b1;
                        end
                        else
                        begin
                            fin_err_next = 1'b1;
                        end
                    end

                    OP_FPAGE, OP_FFILE:
                    begin
                        if (found_reg)
                        begin
                            fr_next              = idx_reg;
                            upd_next             = U_FLUSH;
                            valid_next[idx_reg]  = 1'b0;
                            dirty_next[idx_reg]  = 1'b0;
                            busy_next            = busy_reg - 1'b1;
                            free_next            = free_reg + 1'b1;
                            if (dirty_reg[idx_reg])
                            begin
                                wb_frame_next = idx_reg;
                                wb_file_next  = m_file_reg;
                                wb_page_next  = m_page_reg;
                                ret_next      = S_UPD;
                                state_next    = S_WB;
                            end
                            else
                            begin
                                state_next = S_UPD;
                                scan_go    = 1'b1;
                            end
                            if (op_reg == OP_FPAGE)
                            begin
                                fin_frame_next = idx_reg;
                                fin_hit_next   = 1'b1;
                            end
                        end
                        else if (op_reg == OP_FPAGE)
                        begin
                            fin_err_next = 1'b1;
                        end
                    end

                    OP_FALL:
                    begin
                        rk_cnt_next = '0;
                        scan_go     = 1'b1;
                        if (busy_reg == '0)
                        begin
                            upd_next   = U_REL;
                            state_next = S_UPD;
                        end
                        else
                        begin
                            state_next = S_RANK;
                        end
                    end

                    OP_CLEAR:
                    begin
                        upd_next   = U_REL;
                        state_next = S_UPD;
                        scan_go    = 1'b1;
                    end

                    default:
                    begin
                        fin_err_next = 1'b1;
                    end
                endcase
            end

            S_UPD:
            begin
                if (pv_reg)
                begin
                    case (upd_reg)
                        U_HIT:
                        begin
                            if (pi_reg == fr_reg)
                            begin
                                pos_n = '0;
                            end
                            else if (v_i && rd_pos < rank_reg)
                            begin
                                pos_n = rd_pos + 1'b1;
                            end
                        end
                        U_ACQ:
                        begin
                            if (pi_reg == fr_reg)
                            begin
                                pos_n = '0;
                            end
                            else if (v_i)
                            begin
                                pos_n = rd_pos + 1'b1;
                            end
                            else if (from_free_reg)
                            begin
                                pos_n = rd_pos - 1'b1;
                            end
                        end
                        U_FLUSH:
                        begin
                            if (pi_reg == fr_reg)
                            begin
                                pos_n = '0;
                            end
                            else if (v_i && rd_pos > rank_reg)
                            begin
                                pos_n = rd_pos - 1'b1;
                            end
                            else if (!v_i)
                            begin
                                pos_n = rd_pos + 1'b1;
                            end
                        end
                        U_REL:
                        begin
                            // append recency order to the free tail
                            if (v_i)
                            begin
                                pos_n = FW'(free_reg + CW'(rd_pos));
                            end
                        end
                        default:
                        begin
                            pos_n = rd_pos;
                        end
                    endcase
                    pos_we    = 1'b1;
                    pos_wdata = pos_n;
                end
                if (scan_done)
                begin
                    if (upd_reg == U_REL)
                    begin
                        valid_next = '0;
                        dirty_next = '0;
                        free_next  = CW'(FRAMES);
                        busy_next  = '0;
                        state_next = S_FIN;
                    end
                    else if (op_reg == OP_FFILE)
                    begin
                        found_next = 1'b0;
                        state_next = S_LOOK;
                        scan_go    = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_RANK:
            begin
                if (pv_reg && v_i && rd_pos == rk_cnt_reg[FW-1:0])
                begin
                    idx_next    = pi_reg;
                    m_file_next = rd_file;
                    m_page_next = rd_page;
                end
                if (scan_done)
                begin
                    rk_cnt_next = rk_cnt_reg + 1'b1;
                    state_next  = S_RNEXT;
                end
            end

            S_RNEXT:
            begin
                if (dirty_reg[idx_reg])
                begin
                    dirty_next[idx_reg] = 1'b0;
                    wb_frame_next       = idx_reg;
                    wb_file_next        = m_file_reg;
                    wb_page_next        = m_page_reg;
                    ret_next            = S_RNEXT;
                    state_next          = S_WB;
                end
                else if (rk_cnt_reg == busy_reg)
                begin
                    upd_next   = U_REL;
                    state_next = S_UPD;
                    scan_go    = 1'b1;
                end
                else
                begin
                    state_next = S_RANK;
                    scan_go    = 1'b1;
                end
            end

            S_WB:
            begin
                emit.vld   = 1'b1;
                emit.frame = OUT_FRAME_W'(8'(wb_frame_reg));
                emit.file  = wb_file_reg;
                emit.page  = wb_page_reg;
                if (emit_take)
                begin
                    state_next = ret_reg;
                    scan_go    = (ret_reg == S_UPD);
                end
            end

            S_FIN:
            begin
                emit.vld         = 1'b1;
                emit.last        = 1'b1;
                emit.frame       = OUT_FRAME_W'(8'(fin_frame_reg));
                emit.hit         = fin_hit_reg;
                emit.read_needed = fin_rd_reg;
                emit.error       = fin_err_reg;
                emit.file        = f_reg;
                emit.page        = p_reg;
                if (emit_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (scan_go)
        begin
            cnt_next = '0;
            iss_next = 1'b1;
            pv_next  = 1'b0;
        end
    end

endmodule

// File: rtl/lru_page_buffer_pool.sv
// Buffer pool frame manager: maps (file, page) to FRAMES frames with LRU
// replacement, a free list and dirty write-back. One request is taken at a
// time; every step walks the frames one per cycle through the single read
// port of the tag/position memory. A hit or miss takes a lookup pass, then
// a list update pass, plus result handshakes; flush file repeats lookup and
// update once per matching frame; flush all spends a scan pass per resident
// frame to walk recency order, then one more pass. After reset a pass over
// the frames sets up the free list before the first item is taken. Results
// leave through an output register; a request yields zero or more
// write-back items (last low) and then one final item.
// Depends on lpbp_pkg, lpbp_ctrl, lpbp_frame_store and the defines header.
`include "lru_page_buffer_pool_defines.svh"

module lru_page_buffer_pool #(
    parameter int FRAMES = lpbp_pkg::FRAMES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [lpbp_pkg::OP_W-1:0]        opcode,
    input  logic [lpbp_pkg::FILE_W-1:0]      file_id,
    input  logic [lpbp_pkg::PAGE_W-1:0]      page_number,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             last,
    output logic [lpbp_pkg::OUT_FRAME_W-1:0] frame,
    output logic                             hit,
    output logic                             read_needed,
    output logic                             error,
    output logic [lpbp_pkg::FILE_W-1:0]      out_file_id,
    output logic [lpbp_pkg::PAGE_W-1:0]      out_page_number
);
    import lpbp_pkg::*;

    localparam int FW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);

    logic              in_ready;
    logic              in_accept;
    emit_t             emit;
    logic              emit_take;
    logic [FW-1:0]     rd_addr;
    logic [FILE_W-1:0] rd_file;
    logic [PAGE_W-1:0] rd_page;
    logic [FW-1:0]     rd_pos;
    tag_wr_t           tag_wr;
    logic [FW-1:0]     tag_addr;
    logic              pos_we;
    logic [FW-1:0]     pos_addr;
    logic [FW-1:0]     pos_wdata;
    logic [CW-1:0]     busy_cnt;
    logic [CW-1:0]     free_cnt;

    logic  out_valid_reg, out_valid_next;
    emit_t out_reg, out_next;

    assign in_stall  = !in_ready;
    assign in_accept = in_valid && in_ready;
    assign emit_take = !out_valid_reg || !out_stall;

    lpbp_ctrl #(.FRAMES(FRAMES)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .opcode      (opcode),
        .file_id     (file_id),
        .page_number (page_number),
        .in_ready    (in_ready),
        .emit        (emit),
        .emit_take   (emit_take),
        .rd_addr     (rd_addr),
        .rd_file     (rd_file),
        .rd_page     (rd_page),
        .rd_pos      (rd_pos),
        .tag_wr      (tag_wr),
        .tag_addr    (tag_addr),
        .pos_we      (pos_we),
        .pos_addr    (pos_addr),
        .pos_wdata   (pos_wdata),
        .busy_cnt    (busy_cnt),
        .free_cnt    (free_cnt)
    );

    lpbp_frame_store #(.FRAMES(FRAMES)) u_store (
        .clk       (clk),
        .rd_addr   (rd_addr),
        .rd_file   (rd_file),
        .rd_page   (rd_page),
        .rd_pos    (rd_pos),
        .tag_wr    (tag_wr),
        .tag_addr  (tag_addr),
        .pos_we    (pos_we),
        .pos_addr  (pos_addr),
        .pos_wdata (pos_wdata)
    );

    // load a new item whenever the register is empty or being drained
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit_take)
        begin
            out_valid_next = emit.vld;
            out_next       = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid       = out_valid_reg;
    assign last            = out_reg.last;
    assign frame           = out_reg.frame;
    assign hit             = out_reg.hit;
    assign read_needed     = out_reg.read_needed;
    assign error           = out_reg.error;
    assign out_file_id     = out_reg.file;
    assign out_page_number = out_reg.page;

    `LPBP_ASSERT_ALWAYS(a_frames_conserved, ({1'b0, busy_cnt} + {1'b0, free_cnt}) == (CW+1)'(FRAMES), "resident plus free frames differ from pool size")
    `LPBP_ASSERT_NEXT(a_one_item_at_a_time, in_valid && !in_stall, in_stall, "new item taken while one is in progress")
    `LPBP_ASSERT_ALWAYS(a_writeback_clean, !(out_valid && !last) || (!hit && !read_needed && !error), "write-back item carries status flags")

endmodule
